FILE: rtl/core/imrru_pkg.sv
// Package: sizes, command and status codes, Q16.16 rounding and saturation helpers.
`timescale 1ns / 1ps
package imrru_pkg;

    localparam int SITES    = 16;
    localparam int HALF_E   = 8;
    localparam int HE_W     = (HALF_E > 1) ? $clog2(HALF_E) : 1;
    localparam int ORB_D    = SITES * HALF_E;
    localparam int ORB_AW   = (ORB_D > 1) ? $clog2(ORB_D) : 1;
    localparam int INV_D    = 2 * HALF_E * HALF_E;
    localparam int INV_AW   = $clog2(INV_D);
    localparam int DIV_STEPS = 33;
    localparam int DIV_CW   = $clog2(DIV_STEPS + 1);

    localparam logic [1:0] CMD_LOAD_ORB = 2'd0;
    localparam logic [1:0] CMD_LOAD_INV = 2'd1;
    localparam logic [1:0] CMD_UPDATE   = 2'd2;
    localparam logic [1:0] CMD_READ_INV = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic signed [32:0] ONE_Q = 33'sd65536;

    // nearest, ties toward plus infinity
    function automatic logic signed [49:0] round_q(input logic signed [65:0] x);
        logic signed [65:0] w;
        begin
            w = x + 66'sd32768;
            return w[65:16];
        end
    endfunction

    function automatic logic ovf32(input logic signed [51:0] v);
        return (v > 52'sd2147483647) || (v < -52'sd2147483648);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        logic signed [31:0] r;
        begin
            if (v > 52'sd2147483647)
                r = 32'sh7fffffff;
            else if (v < -52'sd2147483648)
                r = 32'sh80000000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage

FILE: rtl/core/inverse_matrix_row_replace_update.sv
// Top level: Sherman-Morrison row-replacement update of two inverse matrices.
//
//  channel | direction | handshake           | beat fields
//  --------+-----------+---------------------+-----------------------------------------
//  input   | in        | in_valid / in_stall | command spin row_index col_index
//          |           |                     | entry_value arrive_site leave_column
//  output  | out       | out_valid/out_stall | read_value ratio status
//
//  Loads are written as they are taken; a read passes through the read state.
//  An update runs: dot sweep, check, column copy, divide (one quotient bit a
//  cycle), h, row sweep, finish; a zero ratio goes from check to finish.
//  The steps take turns on the shared 33 x 33 multiplier and inverse read port.
//  rst_n clears control only; the matrices hold nothing defined until loaded.
//  in_stall is high whenever a beat is in progress or the result register
//  stays full; out_stall just holds the result register.
`timescale 1ns / 1ps
module inverse_matrix_row_replace_update
    import imrru_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic               spin,
    input  logic [3:0]         row_index,
    input  logic [2:0]         col_index,
    input  logic signed [31:0] entry_value,
    input  logic [3:0]         arrive_site,
    input  logic [2:0]         leave_column,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] read_value,
    output logic signed [31:0] ratio,
    output logic [1:0]         status
);

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_DOT, S_CHECK, S_COPY, S_DIV, S_HSET,
        S_UPH, S_UPP, S_UPJ, S_UPW, S_FIN
    } state_t;

    localparam logic [HE_W-1:0] HE_LAST = HE_W'(HALF_E - 1);

    state_t state_reg;

    // memories
    logic signed [31:0] orb_mem [ORB_D];
    logic signed [31:0] inv_mem [INV_D];
    logic signed [31:0] orb_rd_reg;
    logic signed [31:0] inv_rd_reg;

    // scratch: row products and leave column copy
    logic signed [31:0] rprod_reg [HALF_E];
    logic signed [31:0] lcol_reg  [HALF_E];

    // control registers
    logic               out_valid_reg;
    logic signed [31:0] read_value_reg;
    logic signed [31:0] ratio_reg;
    logic [1:0]         status_reg;
    logic               spin_reg;
    logic [HE_W-1:0]    leave_reg;
    logic [3:0]         arrive_reg;
    logic [HE_W-1:0]    i_reg, j_reg, k_reg;
    logic               iss_reg;
    logic               v1_reg, v2_reg;
    logic [HE_W-1:0]    k1_reg, j1_reg, k2_reg, j2_reg;
    logic               cv_reg;
    logic [HE_W-1:0]    ci_reg;
    logic               wv_reg;
    logic [HE_W-1:0]    wi_reg, wj_reg;
    logic               sat_reg;
    logic               zero_reg;
    logic [DIV_CW-1:0]  div_cnt_reg;

    // datapath registers
    logic signed [65:0] prod_reg;
    logic signed [51:0] acc_reg;
    logic signed [31:0] h_reg;
    logic signed [31:0] p_reg;
    logic [31:0]        m_reg;
    logic [32:0]        num_reg;
    logic [32:0]        rem_reg;
    logic [32:0]        q_reg;

    // combinational
    logic               accept;
    logic               row_inv_ok, col_ok, row_orb_ok;
    logic               rd_ok, upd_ok, res_set;
    logic [ORB_AW-1:0]  orb_waddr, orb_raddr;
    logic [INV_AW-1:0]  inv_in_addr, inv_raddr, inv_waddr;
    logic signed [32:0] mul_a, mul_b;
    logic signed [51:0] dot_sum;
    logic signed [51:0] new_val;
    logic signed [51:0] p_wide;
    logic signed [32:0] c_j;
    logic signed [31:0] d_val;
    logic [32:0]        trial;
    logic signed [34:0] h_wide;

    assign accept     = in_valid && !in_stall;
    assign in_stall   = !((state_reg == S_IDLE) && (!out_valid_reg || !out_stall));
    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign ratio      = ratio_reg;
    assign status     = status_reg;

    assign row_orb_ok = 32'(row_index) < SITES;
    assign row_inv_ok = 32'(row_index) < HALF_E;
    assign col_ok     = 32'(col_index) < HALF_E;

    assign rd_ok  = (command == CMD_READ_INV) && row_inv_ok && col_ok;
    assign upd_ok = (command == CMD_UPDATE) && (32'(arrive_site) < SITES)
                    && (32'(leave_column) < HALF_E);
    // a result beat is loaded this cycle
    assign res_set = ((state_reg == S_IDLE) && accept && !rd_ok && !upd_ok)
                     || (((state_reg == S_READ) || (state_reg == S_FIN)) && !out_valid_reg);

    function automatic logic [INV_AW-1:0] inv_addr(input logic s, input logic [7:0] r,
                                                   input logic [7:0] c);
        return INV_AW'(INV_AW'(s) * INV_AW'(HALF_E * HALF_E)
                       + INV_AW'(r) * INV_AW'(HALF_E) + INV_AW'(c));
    endfunction

    assign orb_waddr   = ORB_AW'(ORB_AW'(row_index) * ORB_AW'(HALF_E) + ORB_AW'(col_index));
    assign orb_raddr   = ORB_AW'(ORB_AW'(arrive_reg) * ORB_AW'(HALF_E) + ORB_AW'(k_reg));
    assign inv_in_addr = inv_addr(spin, 8'(row_index), 8'(col_index));
    assign inv_waddr   = inv_addr(spin_reg, 8'(wi_reg), 8'(wj_reg));

    always_comb
    begin
        unique case (state_reg)
            S_DOT:   inv_raddr = inv_addr(spin_reg, 8'(k_reg), 8'(j_reg));
            S_COPY:  inv_raddr = inv_addr(spin_reg, 8'(i_reg), 8'(leave_reg));
            S_UPJ:   inv_raddr = inv_addr(spin_reg, 8'(i_reg), 8'(j_reg));
            default: inv_raddr = inv_in_addr;
        endcase
    end

    // shared multiplier operand select
    assign c_j = 33'(rprod_reg[j_reg]) - ((j_reg == leave_reg) ? ONE_Q : 33'sd0);
    always_comb
    begin
        unique case (state_reg)
            S_UPH:
            begin
                mul_a = 33'(h_reg);
                mul_b = 33'(lcol_reg[i_reg]);
            end
            S_UPJ:
            begin
                mul_a = 33'(p_reg);
                mul_b = c_j;
            end
            default:
            begin
                mul_a = 33'(orb_rd_reg);
                mul_b = 33'(inv_rd_reg);
            end
        endcase
    end

    assign dot_sum = acc_reg + 52'(round_q(prod_reg));
    assign new_val = 52'(inv_rd_reg) + 52'(round_q(prod_reg));
    assign p_wide  = 52'(round_q(prod_reg));
    assign d_val   = rprod_reg[leave_reg];
    assign trial   = {rem_reg[31:0], num_reg[32]};
    assign h_wide  = (!d_val[31]) ? -$signed({2'b00, q_reg}) : $signed({2'b00, q_reg});

    // sequencer, tags and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            read_value_reg <= '0;
            ratio_reg      <= '0;
            status_reg     <= ST_OK;
            spin_reg       <= 1'b0;
            leave_reg      <= '0;
            arrive_reg     <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            iss_reg        <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            k1_reg         <= '0;
            j1_reg         <= '0;
            k2_reg         <= '0;
            j2_reg         <= '0;
            cv_reg         <= 1'b0;
            ci_reg         <= '0;
            wv_reg         <= 1'b0;
            wi_reg         <= '0;
            wj_reg         <= '0;
            sat_reg        <= 1'b0;
            zero_reg       <= 1'b0;
            div_cnt_reg    <= '0;
        end
        else
        begin
            if (res_set)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            v1_reg <= (state_reg == S_DOT) && iss_reg;
            k1_reg <= k_reg;
            j1_reg <= j_reg;
            v2_reg <= v1_reg;
            k2_reg <= k1_reg;
            j2_reg <= j1_reg;
            cv_reg <= (state_reg == S_COPY) && iss_reg;
            ci_reg <= i_reg;
            wv_reg <= (state_reg == S_UPJ);
            wi_reg <= i_reg;
            wj_reg <= j_reg;

            if (v2_reg && (k2_reg == HE_LAST) && ovf32(dot_sum))
                sat_reg <= 1'b1;
            if (wv_reg && ovf32(new_val))
                sat_reg <= 1'b1;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        spin_reg       <= spin;
                        arrive_reg     <= arrive_site;
                        leave_reg      <= HE_W'(leave_column);
                        read_value_reg <= '0;
                        ratio_reg      <= '0;
                        status_reg     <= ST_OK;
                        if (rd_ok)
                            state_reg <= S_READ;
                        else if (upd_ok)
                        begin
                            state_reg <= S_DOT;
                            iss_reg   <= 1'b1;
                            j_reg     <= '0;
                            k_reg     <= '0;
                            sat_reg   <= 1'b0;
                        end
                    end
                end
                S_READ:
                begin
                    if (!out_valid_reg)
                    begin
                        read_value_reg <= inv_rd_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                S_DOT:
                begin
                    if (iss_reg)
                    begin
                        if (k_reg == HE_LAST)
                        begin
                            k_reg <= '0;
                            j_reg <= j_reg + 1'b1;
                            if (j_reg == HE_LAST)
                                iss_reg <= 1'b0;
                        end
                        else
                            k_reg <= k_reg + 1'b1;
                    end
                    if (v2_reg && (k2_reg == HE_LAST) && (j2_reg == HE_LAST))
                        state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    zero_reg <= (d_val == 32'sd0);
                    if (d_val == 32'sd0)
                        state_reg <= S_FIN;
                    else
                    begin
                        state_reg <= S_COPY;
                        i_reg     <= '0;
                        iss_reg   <= 1'b1;
                    end
                end
                S_COPY:
                begin
                    if (iss_reg)
                    begin
                        i_reg <= i_reg + 1'b1;
                        if (i_reg == HE_LAST)
                            iss_reg <= 1'b0;
                    end
                    if (cv_reg && (ci_reg == HE_LAST))
                    begin
                        state_reg   <= S_DIV;
                        div_cnt_reg <= '0;
                    end
                end
                S_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == DIV_CW'(DIV_STEPS - 1))
                        state_reg <= S_HSET;
                end
                S_HSET:
                begin
                    if (ovf32(52'(h_wide)))
                        sat_reg <= 1'b1;
                    i_reg     <= '0;
                    state_reg <= S_UPH;
                end
                S_UPH:
                    state_reg <= S_UPP;
                S_UPP:
                begin
                    if (ovf32(p_wide))
                        sat_reg <= 1'b1;
                    j_reg     <= '0;
                    state_reg <= S_UPJ;
                end
                S_UPJ:
                begin
                    j_reg <= j_reg + 1'b1;
                    if (j_reg == HE_LAST)
                    begin
                        if (i_reg == HE_LAST)
                            state_reg <= S_UPW;
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_UPH;
                        end
                    end
                end
                S_UPW:
                    state_reg <= S_FIN;
                S_FIN:
                begin
                    if (!out_valid_reg)
                    begin
                        ratio_reg     <= d_val;
                        status_reg    <= zero_reg ? ST_ZERO : (sat_reg ? ST_SAT : ST_OK);
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath and memories
    always_ff @(posedge clk)
    begin
        orb_rd_reg <= orb_mem[orb_raddr];
        inv_rd_reg <= inv_mem[inv_raddr];
        prod_reg   <= mul_a * mul_b;

        if (accept && command == CMD_LOAD_ORB && row_orb_ok && col_ok)
            orb_mem[orb_waddr] <= entry_value;

        if (accept && command == CMD_LOAD_INV && row_inv_ok && col_ok)
            inv_mem[inv_in_addr] <= entry_value;
        else if (wv_reg)
            inv_mem[inv_waddr] <= sat32(new_val);

        if (state_reg == S_IDLE)
            acc_reg <= '0;
        else if (v2_reg)
        begin
            if (k2_reg == HE_LAST)
            begin
                rprod_reg[j2_reg] <= sat32(dot_sum);
                acc_reg           <= '0;
            end
            else
                acc_reg <= dot_sum;
        end

        if (cv_reg)
            lcol_reg[ci_reg] <= inv_rd_reg;

        // divider: (2^32 + m/2) / m, one quotient bit a cycle
        if (state_reg == S_CHECK)
        begin
            m_reg   <= d_val[31] ? 32'(-d_val) : 32'(d_val);
            num_reg <= {1'b1, (d_val[31] ? 32'(-d_val) : 32'(d_val)) >> 1};
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (state_reg == S_DIV)
        begin
            num_reg <= {num_reg[31:0], 1'b0};
            if (trial >= {1'b0, m_reg})
            begin
                rem_reg <= trial - {1'b0, m_reg};
                q_reg   <= {q_reg[31:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[31:0], 1'b0};
            end
        end

        if (state_reg == S_HSET)
            h_reg <= sat32(52'(h_wide));
        if (state_reg == S_UPP)
            p_reg <= sat32(p_wide);
    end

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> m_reg != 32'd0)
        else $error("divide with zero divisor");

    a_fin_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && !out_valid_reg) |=> out_valid_reg)
        else $error("update result not presented");

    a_zero_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_ZERO) |-> ratio_reg == 32'sd0)
        else $error("zero ratio status with nonzero ratio");

    a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> (!out_valid_reg || !out_stall))
        else $error("beat taken while result register blocked");

endmodule
